[hw/rtl/dci_pkg.sv]
// Shared types, constants and table functions for the date calendar block.
// Used by the interfaces, the three pipeline stages and the top level.
// No dependencies.
package dci_pkg;

  localparam int unsigned DayW   = 6;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CentW  = 8;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned DowW   = 3;
  localparam int unsigned WoyW   = 6;
  localparam int unsigned ZsumW  = 11;
  localparam int unsigned ZtermW = 6;

  localparam logic [YearW-1:0] YearMin = 14'd1000;
  localparam logic [YearW-1:0] YearMax = 14'd9999;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // Division by 100 as a multiplication by a scaled reciprocal.
  localparam int unsigned      Div100Shift = 19;
  localparam logic [12:0]      Div100Mul   = 13'd5243;
  localparam int unsigned      Div100ProdW = YearW + 13;
  localparam logic [YearW-1:0] Hundred     = 14'd100;

  // Division by 7 for the week number, valid for dividends below 512.
  localparam int unsigned Div7Shift = 11;
  localparam logic [8:0]  Div7Mul   = 9'd293;
  localparam int unsigned Div7ProdW = DoyW + 9;

  localparam logic [DowW-1:0] Seven = 3'd7;

  typedef struct packed {
    logic [DayW-1:0]   day_of_month;
    logic [MonthW-1:0] month_number;
    logic [YearW-1:0]  year_number;
  } dci_req_t;

  typedef struct packed {
    logic            date_valid;
    logic [DoyW-1:0] day_of_year;
    logic [DowW-1:0] day_of_week;
    logic [WoyW-1:0] week_of_year;
  } dci_rsp_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [YearW-1:0]  year_z;
    logic [CentW-1:0]  cent;
    logic [CentW-1:0]  cent_z;
    logic              base_ok;
  } dci_s1_t;

  typedef struct packed {
    logic             date_ok;
    logic [DoyW-1:0]  doy;
    logic [ZsumW-1:0] zsum;
  } dci_s2_t;

  function automatic logic [4:0] month_len(input logic [MonthW-1:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month term of Zeller's congruence, with January and February taken
  // as months 13 and 14 of the previous year.
  function automatic logic [ZtermW-1:0] zeller_term(input logic [MonthW-1:0] m);
    logic [ZtermW-1:0] r;
    unique case (m)
      4'd1:    r = 6'd36;
      4'd2:    r = 6'd39;
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dci_req_if.sv]
// Request channel carrying one date with a valid/ready handshake.
// Depends on dci_pkg for the field widths.
interface dci_req_if;
  import dci_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   day_of_month;
  logic [MonthW-1:0] month_number;
  logic [YearW-1:0]  year_number;

  modport source (output valid, day_of_month, month_number, year_number, input ready);
  modport sink   (input valid, day_of_month, month_number, year_number, output ready);
endinterface

[hw/rtl/dci_rsp_if.sv]
// Response channel carrying the calendar facts with a valid/ready handshake.
// Depends on dci_pkg for the field widths.
interface dci_rsp_if;
  import dci_pkg::*;

  logic            valid;
  logic            ready;
  logic            date_valid;
  logic [DoyW-1:0] day_of_year;
  logic [DowW-1:0] day_of_week;
  logic [WoyW-1:0] week_of_year;

  modport source (output valid, date_valid, day_of_year, day_of_week, week_of_year,
                  input ready);
  modport sink   (input valid, date_valid, day_of_year, day_of_week, week_of_year,
                  output ready);
endinterface

[hw/rtl/dci_split.sv]
// First stage: range checks and the division of the year by 100.
// Depends on dci_pkg.
module dci_split (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dci_pkg::dci_req_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dci_pkg::dci_s1_t  data_o
);
  import dci_pkg::*;

  logic                   valid_q;
  dci_s1_t                data_d, data_q;
  logic [YearW-1:0]       year_z;
  logic [Div100ProdW-1:0] prod_y, prod_z;

  assign year_z = (data_i.month_number <= MonFeb) ? data_i.year_number - 14'd1
                                                  : data_i.year_number;
  assign prod_y = Div100ProdW'(data_i.year_number) * Div100ProdW'(Div100Mul);
  assign prod_z = Div100ProdW'(year_z) * Div100ProdW'(Div100Mul);

  always_comb begin
    data_d.day     = data_i.day_of_month;
    data_d.month   = data_i.month_number;
    data_d.year    = data_i.year_number;
    data_d.year_z  = year_z;
    data_d.cent    = prod_y[Div100Shift +: CentW];
    data_d.cent_z  = prod_z[Div100Shift +: CentW];
    data_d.base_ok = (data_i.month_number >= MonJan) && (data_i.month_number <= MonDec) &&
                     (data_i.year_number >= YearMin) && (data_i.year_number <= YearMax) &&
                     (data_i.day_of_month != '0);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end
endmodule

[hw/rtl/dci_calc.sv]
// Second stage: leap year, day check, ordinal day and the Zeller sum.
// Depends on dci_pkg.
module dci_calc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dci_pkg::dci_s1_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dci_pkg::dci_s2_t data_o
);
  import dci_pkg::*;

  logic             valid_q;
  dci_s2_t          data_d, data_q;
  logic [YearW-1:0] rem_y, rem_z;
  logic [6:0]       yy, yy_z;
  logic             leap;
  logic [4:0]       lim;

  assign rem_y = data_i.year   - YearW'(data_i.cent)   * Hundred;
  assign rem_z = data_i.year_z - YearW'(data_i.cent_z) * Hundred;
  assign yy    = rem_y[6:0];
  assign yy_z  = rem_z[6:0];
  assign leap  = (data_i.year[1:0] == 2'b00) && ((yy != '0) || (data_i.cent[1:0] == 2'b00));
  assign lim   = ((data_i.month == MonFeb) && leap) ? 5'd29 : month_len(data_i.month);

  always_comb begin
    data_d.date_ok = data_i.base_ok && (data_i.day <= DayW'(lim));
    data_d.doy     = days_before(data_i.month) + DoyW'(data_i.day) +
                     DoyW'((data_i.month > MonFeb) && leap);
    data_d.zsum    = ZsumW'(data_i.day) + ZsumW'(zeller_term(data_i.month)) +
                     ZsumW'(yy_z) + ZsumW'(yy_z >> 2) + ZsumW'(data_i.cent_z >> 2) +
                     (ZsumW'(data_i.cent_z) << 2) + ZsumW'(data_i.cent_z);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end
endmodule

[hw/rtl/dci_fin.sv]
// Third stage and output register: weekday modulo 7 and week number.
// Depends on dci_pkg.
module dci_fin (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dci_pkg::dci_s2_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dci_pkg::dci_rsp_t data_o
);
  import dci_pkg::*;

  logic                 valid_q;
  dci_rsp_t             data_d, data_q;
  logic [4:0]           fold1;
  logic [3:0]           fold2;
  logic [DowW-1:0]      dow;
  logic [DoyW-1:0]      doy_up;
  logic [Div7ProdW-1:0] prod_w;

  // Powers of eight are one modulo seven, so octal digits can be summed.
  assign fold1 = 5'(data_i.zsum[2:0]) + 5'(data_i.zsum[5:3]) +
                 5'(data_i.zsum[8:6]) + 5'(data_i.zsum[10:9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign dow   = (fold2 >= 4'(Seven)) ? DowW'(fold2 - 4'(Seven)) : DowW'(fold2);

  assign doy_up = data_i.doy + 9'd6;
  assign prod_w = Div7ProdW'(doy_up) * Div7ProdW'(Div7Mul);

  always_comb begin
    data_d.date_valid   = data_i.date_ok;
    data_d.day_of_year  = data_i.date_ok ? data_i.doy : '0;
    data_d.day_of_week  = data_i.date_ok ? dow : '0;
    data_d.week_of_year = data_i.date_ok ? prod_w[Div7Shift +: WoyW] : '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end
endmodule

[hw/rtl/date_calendar_info_core.sv]
// Top level of the date calendar block: three-stage pipeline.
// Depends on dci_pkg, dci_req_if, dci_rsp_if, dci_split, dci_calc and dci_fin.
//
// Usage: a request on req_i carries one Gregorian date (day, month, year).
// For each request the block returns exactly one response on rsp_o, in
// order: date_valid, and for a valid date the day of the year, the Zeller
// weekday (0 is Saturday) and the week of the year; for an invalid date the
// three fields are zero.
// Each request passes through the three register stages (year division,
// calendar sums, weekday and week reduction) before its response appears
// on rsp_o. Throughput is one request per cycle while rsp_o.ready is high.
// Reset clears the valid bits of all stages; no clearing pass is needed.
// When the receiver holds rsp_o.ready low the response stays stable and
// each stage keeps accepting until it holds a request of its own, so up to
// three requests are held before req_i.ready falls; nothing is lost.
module date_calendar_info_core (
  input logic   clk_i,
  input logic   rst_ni,
  dci_req_if.sink   req_i,
  dci_rsp_if.source rsp_o
);
  import dci_pkg::*;

  dci_req_t req;
  dci_s1_t  s1_data;
  dci_s2_t  s2_data;
  dci_rsp_t rsp;
  logic     s1_valid, s1_ready;
  logic     s2_valid, s2_ready;

  assign req.day_of_month = req_i.day_of_month;
  assign req.month_number = req_i.month_number;
  assign req.year_number  = req_i.year_number;

  dci_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  dci_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  dci_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (rsp)
  );

  assign rsp_o.date_valid   = rsp.date_valid;
  assign rsp_o.day_of_year  = rsp.day_of_year;
  assign rsp_o.day_of_week  = rsp.day_of_week;
  assign rsp_o.week_of_year = rsp.week_of_year;
endmodule

[hw/rtl/dci_checker.sv]
// Port-level checks for the date calendar block, attached by bind.
// Depends on dci_pkg and on the ports of date_calendar_info_core.
module dci_checker
  import dci_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic            date_valid_i,
  input logic [DoyW-1:0] day_of_year_i,
  input logic [DowW-1:0] day_of_week_i,
  input logic [WoyW-1:0] week_of_year_i
);

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(date_valid_i) &&
      $stable(day_of_year_i) && $stable(day_of_week_i) && $stable(week_of_year_i))
    else $error("response changed while stalled");

  // An invalid date reports zero in every other field.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !date_valid_i |->
      day_of_year_i == '0 && day_of_week_i == '0 && week_of_year_i == '0)
    else $error("invalid date with nonzero fields");

  // A valid date has a day of the year from 1 to 366 and a weekday below 7.
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && date_valid_i |->
      day_of_year_i != '0 && day_of_year_i <= 9'd366 && day_of_week_i <= 3'd6)
    else $error("valid date with out-of-range fields");

  // The week number is the ceiling of the day of the year over seven.
  a_week_ceil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && date_valid_i |->
      (12'(week_of_year_i) * 12'd7 >= 12'(day_of_year_i)) &&
      (12'(week_of_year_i) * 12'd7 < 12'(day_of_year_i) + 12'd7))
    else $error("week of year does not match day of year");

endmodule

bind date_calendar_info_core dci_checker u_dci_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .date_valid_i   (rsp_o.date_valid),
  .day_of_year_i  (rsp_o.day_of_year),
  .day_of_week_i  (rsp_o.day_of_week),
  .week_of_year_i (rsp_o.week_of_year)
);
